### hw/rtl/plti_pkg.sv
// shared types and constants of the piecewise linear table lookup
package plti_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int SIZE_W  = 7;
  localparam int INDEX_W = 6;
  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 17;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_INTERP = 3'd1,
    KIND_LOW    = 3'd2,
    KIND_HIGH   = 3'd3,
    KIND_ZERO   = 3'd4
  } kind_t;

  typedef struct packed {
    logic               req_type;
    logic [INDEX_W-1:0] entry_index;
    logic [DATA_W-1:0]  breakpoint_in;
    logic [DATA_W-1:0]  entry_value;
    logic [DATA_W-1:0]  query_point;
  } req_t;

endpackage

### hw/rtl/plti_front.sv
// request intake and two-entry queue toward the execution unit
module plti_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  plti_pkg::req_t req_in,
  output logic           head_valid,
  output plti_pkg::req_t head,
  input  logic           head_take
);

  plti_pkg::req_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign busy       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];
  assign push       = start && !busy;
  assign pop        = head_valid && head_take;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |=> count != 2'd0 || $past(pop))
    else $error("queue drained without a pop");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != 2'd0)
    else $error("pop from empty queue");

endmodule

### hw/rtl/plti_back.sv
// table storage, binary search, fraction divider and blend
module plti_back #(
  parameter int MAX_ENTRIES = plti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [plti_pkg::SIZE_W-1:0]   table_size,
  input  logic                          head_valid,
  input  plti_pkg::req_t                head,
  output logic                          head_take,
  output logic                          result_valid,
  output logic [plti_pkg::DATA_W-1:0]   result_value,
  output plti_pkg::kind_t               result_kind
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int SW = $clog2(MAX_ENTRIES + 1);
  localparam int DW = plti_pkg::DATA_W;
  localparam int FW = plti_pkg::FRAC_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PROBE, S_CMP, S_EDGE_RD, S_EDGE_OUT,
    S_RD_L, S_RD_R, S_CAP_R, S_CHK, S_DIV, S_MUL, S_ADD
  } state_t;

  logic [DW-1:0] bp_mem  [MAX_ENTRIES];
  logic [DW-1:0] val_mem [MAX_ENTRIES];
  logic [DW-1:0] bp_q;
  logic [DW-1:0] val_q;
  logic [AW-1:0] rd_addr;

  state_t          state;
  logic [SW-1:0]   size;
  logic [SW-1:0]   left_p1;
  logic [SW-1:0]   right;
  logic [DW-1:0]   query;
  plti_pkg::kind_t edge_kind;
  logic signed [DW-1:0] bl, vl, br, vr;
  logic [DW+1:0]   rem;
  logic [FW-1:0]   frac;
  logic [4:0]      cnt;
  logic signed [DW+FW+1:0] prod;

  logic [SW:0]     span;
  logic [SW:0]     mid_w;
  logic [AW-1:0]   mid;
  logic [SW-1:0]   size_eff;
  logic            take;
  logic            do_write;
  logic signed [DW:0] range;
  logic signed [DW:0] num;
  logic signed [DW:0] diff;
  logic [DW+1:0]   rem_sub;
  logic            rem_ge;

  assign span  = {1'b0, right} - {1'b0, left_p1} + (SW+1)'(1);
  assign mid_w = {1'b0, left_p1} - (SW+1)'(1) + (span >> 1);
  assign mid   = mid_w[AW-1:0];

  always_comb begin
    if (table_size == '0) begin
      size_eff = SW'(1);
    end else if (int'(table_size) > MAX_ENTRIES) begin
      size_eff = SW'(MAX_ENTRIES);
    end else begin
      size_eff = SW'(table_size);
    end
  end

  assign head_take = (state == S_IDLE);
  assign take      = head_valid && head_take;
  assign do_write  = take && head.req_type == plti_pkg::REQ_WRITE
                     && int'(head.entry_index) < MAX_ENTRIES;

  assign range   = {br[DW-1], br} - {bl[DW-1], bl};
  assign num     = $signed({query[DW-1], query}) - {bl[DW-1], bl};
  assign diff    = {vr[DW-1], vr} - {vl[DW-1], vl};
  assign rem_ge  = rem >= {1'b0, range};
  assign rem_sub = rem_ge ? rem - {1'b0, range} : rem;

  always_comb begin
    unique case (state)
      S_PROBE, S_CMP: rd_addr = mid;
      S_EDGE_RD:      rd_addr = (left_p1 == '0) ? '0 : AW'(size - SW'(1));
      S_RD_L:         rd_addr = AW'(left_p1 - SW'(1));
      S_RD_R:         rd_addr = AW'(right);
      default:        rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      bp_mem[AW'(head.entry_index)]  <= head.breakpoint_in;
      val_mem[AW'(head.entry_index)] <= head.entry_value;
    end
    bp_q  <= bp_mem[rd_addr];
    val_q <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            if (head.req_type == plti_pkg::REQ_WRITE) begin
              result_valid <= 1'b1;
              result_value <= '0;
              result_kind  <= plti_pkg::KIND_WRITE;
            end else begin
              query   <= head.query_point;
              size    <= size_eff;
              left_p1 <= '0;
              right   <= size_eff;
              state   <= S_PROBE;
            end
          end
        end
        S_PROBE: state <= S_CMP;
        S_CMP: begin
          if ($signed(bp_q) >= $signed(query)) begin
            right <= SW'(mid);
            state <= (left_p1 == SW'(mid)) ? S_EDGE_RD : S_PROBE;
          end else begin
            left_p1 <= SW'(mid) + SW'(1);
            state   <= (SW'(mid) + SW'(1) == right) ? S_EDGE_RD : S_PROBE;
          end
        end
        S_EDGE_RD: begin
          if (left_p1 == '0) begin
            edge_kind <= plti_pkg::KIND_LOW;
            state     <= S_EDGE_OUT;
          end else if (left_p1 == size) begin
            edge_kind <= plti_pkg::KIND_HIGH;
            state     <= S_EDGE_OUT;
          end else begin
            state <= S_RD_L;
          end
        end
        S_EDGE_OUT: begin
          result_valid <= 1'b1;
          result_value <= val_q;
          result_kind  <= edge_kind;
          state        <= S_IDLE;
        end
        S_RD_L: state <= S_RD_R;
        S_RD_R: begin
          bl    <= $signed(bp_q);
          vl    <= $signed(val_q);
          state <= S_CAP_R;
        end
        S_CAP_R: begin
          br    <= $signed(bp_q);
          vr    <= $signed(val_q);
          state <= S_CHK;
        end
        S_CHK: begin
          if (range == '0) begin
            result_valid <= 1'b1;
            result_value <= '0;
            result_kind  <= plti_pkg::KIND_ZERO;
            state        <= S_IDLE;
          end else begin
            rem   <= {1'b0, num};
            frac  <= '0;
            cnt   <= 5'(FW);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle, msb first
          frac <= {frac[FW-2:0], rem_ge};
          rem  <= {rem_sub[DW:0], 1'b0};
          cnt  <= cnt - 5'd1;
          if (cnt == 5'd1) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, frac});
          state <= S_ADD;
        end
        S_ADD: begin
          result_valid <= 1'b1;
          result_value <= DW'(vl + $signed(prod[DW+15:16]));
          result_kind  <= plti_pkg::KIND_INTERP;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE || state == S_CMP) |-> left_p1 < right && right <= size)
    else $error("search bounds crossed");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt != 5'd0)
    else $error("divider ran past its last bit");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !take)
    else $error("request taken while busy");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EDGE_OUT || state == S_ADD || state == S_CHK
                           || (state == S_IDLE && take)))
    else $error("result without a finished request");

endmodule

### hw/rtl/piecewise_linear_table_interp.sv
// top level of the piecewise linear interpolation lookup table
// A request is taken at a clock edge where start is high and busy is low; a
// two-entry queue sits in front of the execution unit, so busy only rises
// once two requests are waiting. Each request gives exactly one result,
// shown on result_value and result_kind for a single cycle with result_valid
// high; the receiver cannot hold it off and must take it in that cycle.
// A write request (req_type 0) stores one breakpoint/value pair and reports
// in the cycle right after it leaves the queue. A lookup binary-searches the
// first table_size entries, probing through the registered table read port
// (up to log2 of the table size plus one probes), then does two reads for
// the bracketing pair, a 17-bit restoring divide for the Q1.16 fraction, one
// multiply and one add. Clamped lookups skip the divider and report the end
// entry's value once the search is done. table_size is written on its own
// valid/ready channel; the user must write it only while idle, as the block
// itself does not enforce this.
module piecewise_linear_table_interp #(
  parameter int MAX_ENTRIES = plti_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [plti_pkg::INDEX_W-1:0]  entry_index,
  input  logic signed [plti_pkg::DATA_W-1:0] breakpoint_in,
  input  logic signed [plti_pkg::DATA_W-1:0] entry_value,
  input  logic signed [plti_pkg::DATA_W-1:0] query_point,
  // result channel
  output logic                          result_valid,
  output logic signed [plti_pkg::DATA_W-1:0] result_value,
  output logic [2:0]                    result_kind,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [plti_pkg::SIZE_W-1:0]   table_size
);

  plti_pkg::req_t  req_in;
  plti_pkg::req_t  head;
  logic            head_valid;
  logic            head_take;
  plti_pkg::kind_t kind;
  logic [plti_pkg::DATA_W-1:0] value;
  logic [plti_pkg::SIZE_W-1:0] size_reg;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= plti_pkg::SIZE_W'(1);
    end else if (cfg_valid) begin
      size_reg <= table_size;
    end
  end

  assign req_in = '{req_type:      req_type,
                    entry_index:   entry_index,
                    breakpoint_in: breakpoint_in,
                    entry_value:   entry_value,
                    query_point:   query_point};

  // intake queue
  plti_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_in     (req_in),
    .head_valid (head_valid),
    .head       (head),
    .head_take  (head_take)
  );

  // execution: storage, search, divide, blend
  plti_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
    .clk          (clk),
    .rst          (rst),
    .table_size   (size_reg),
    .head_valid   (head_valid),
    .head         (head),
    .head_take    (head_take),
    .result_valid (result_valid),
    .result_value (value),
    .result_kind  (kind)
  );

  assign result_value = $signed(value);
  assign result_kind  = kind;

endmodule

### tb/piecewise_linear_table_interp_tb.sv
// self-checking testbench for the piecewise linear interpolation lookup table
module piecewise_linear_table_interp_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = plti_pkg::MAX_ENTRIES_DEF;
  localparam int ITEMS_PER_PHASE = 260;

  typedef struct {
    logic                         req_type;
    logic [plti_pkg::INDEX_W-1:0] entry_index;
    logic [plti_pkg::DATA_W-1:0]  breakpoint_in;
    logic [plti_pkg::DATA_W-1:0]  entry_value;
    logic [plti_pkg::DATA_W-1:0]  query_point;
  } lut_request_t;

  typedef struct {
    logic signed [plti_pkg::DATA_W-1:0] value;
    plti_pkg::kind_t                    kind;
  } lut_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [plti_pkg::INDEX_W-1:0] entry_index = '0;
  logic signed [plti_pkg::DATA_W-1:0] breakpoint_in = '0;
  logic signed [plti_pkg::DATA_W-1:0] entry_value = '0;
  logic signed [plti_pkg::DATA_W-1:0] query_point = '0;
  logic result_valid;
  logic signed [plti_pkg::DATA_W-1:0] result_value;
  logic [2:0] result_kind;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [plti_pkg::SIZE_W-1:0] table_size = 7'd1;

  piecewise_linear_table_interp dut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .req_type(req_type), .entry_index(entry_index),
    .breakpoint_in(breakpoint_in), .entry_value(entry_value),
    .query_point(query_point),
    .result_valid(result_valid), .result_value(result_value),
    .result_kind(result_kind),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .table_size(table_size)
  );

  // predictor state: the table contents and the size register as the block sees them
  logic signed [plti_pkg::DATA_W-1:0] shadow_bp [DEPTH];
  logic signed [plti_pkg::DATA_W-1:0] shadow_val [DEPTH];
  logic [plti_pkg::SIZE_W-1:0] shadow_size = 7'd1;

  // stimulus side copy, updated as requests are queued, used to aim queries
  logic signed [plti_pkg::DATA_W-1:0] plan_bp [DEPTH];
  int unsigned plan_size = 1;

  lut_request_t pending_requests[$];
  lut_answer_t  expected_answers[$];
  lut_request_t in_flight;
  int unsigned  send_idle_pct = 0;
  int unsigned  error_count = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // limit on the whole run
  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  // compute the answer the block must give for one request
  function automatic lut_answer_t predict_answer(lut_request_t r);
    lut_answer_t a;
    int lo, hi, mid, sz;
    longint q, bl, br, vl, vr, span, num, frac;
    a.value = '0;
    a.kind = plti_pkg::KIND_WRITE;
    if (r.req_type == plti_pkg::REQ_WRITE) begin
      shadow_bp[r.entry_index] = r.breakpoint_in;
      shadow_val[r.entry_index] = r.entry_value;
      return a;
    end
    sz = shadow_size;
    if (sz < 1) sz = 1;
    if (sz > DEPTH) sz = DEPTH;
    q = longint'($signed(r.query_point));
    // binary search with the exact probe order of the block
    lo = -1;
    hi = sz;
    while (lo + 1 != hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (longint'(shadow_bp[mid]) >= q) hi = mid;
      else lo = mid;
    end
    if (lo == -1) begin
      a.value = shadow_val[0];
      a.kind = plti_pkg::KIND_LOW;
      return a;
    end
    if (lo == sz - 1) begin
      a.value = shadow_val[sz-1];
      a.kind = plti_pkg::KIND_HIGH;
      return a;
    end
    bl = shadow_bp[lo];
    br = shadow_bp[hi];
    span = br - bl;
    if (span == 0) begin
      a.kind = plti_pkg::KIND_ZERO;
      return a;
    end
    // floor division for the Q1.16 fraction
    num = (q - bl) * 65536;
    frac = num / span;
    if ((num % span != 0) && ((num < 0) != (span < 0))) frac = frac - 1;
    if (frac < 0) frac = 0;
    if (frac > 65536) frac = 65536;
    vl = shadow_val[lo];
    vr = shadow_val[hi];
    a.value = vl + (((vr - vl) * frac) >>> 16);
    a.kind = plti_pkg::KIND_INTERP;
    return a;
  endfunction

  // request driver: takes requests from the pending queue, idles at random
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_answers.push_back(predict_answer(in_flight));
      if (!start || !busy) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_requests.pop_front();
          req_type <= in_flight.req_type;
          entry_index <= in_flight.entry_index;
          breakpoint_in <= in_flight.breakpoint_in;
          entry_value <= in_flight.entry_value;
          query_point <= in_flight.query_point;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobed result must match the oldest expectation
  always @(posedge clk) begin
    lut_answer_t e;
    if (!rst && result_valid) begin
      if (expected_answers.size() == 0) begin
        $error("unexpected result value=%0d kind=%0d", result_value, result_kind);
        error_count++;
      end else begin
        e = expected_answers.pop_front();
        if (result_value !== e.value) begin
          $error("result_value expected %0d actual %0d", e.value, result_value);
          error_count++;
        end
        if (result_kind !== e.kind) begin
          $error("result_kind expected %0d actual %0d", e.kind, result_kind);
          error_count++;
        end
      end
    end
  end

  task automatic queue_write(int idx, logic [31:0] bp, logic [31:0] val);
    lut_request_t r;
    r.req_type = plti_pkg::REQ_WRITE;
    r.entry_index = idx[plti_pkg::INDEX_W-1:0];
    r.breakpoint_in = bp;
    r.entry_value = val;
    r.query_point = $urandom;
    plan_bp[idx] = bp;
    pending_requests.push_back(r);
  endtask

  task automatic queue_lookup(logic [31:0] q);
    lut_request_t r;
    r.req_type = plti_pkg::REQ_LOOKUP;
    r.entry_index = $urandom;
    r.breakpoint_in = $urandom;
    r.entry_value = $urandom;
    r.query_point = q;
    pending_requests.push_back(r);
  endtask

  // query aimed at the table: at or near a breakpoint, between two, at either end of the range, or anywhere
  function automatic logic [31:0] aimed_query();
    int j;
    j = $urandom_range(plan_size - 1);
    case ($urandom_range(5))
      0: return plan_bp[j];
      1: return plan_bp[j] + $signed($urandom_range(8)) - 4;
      2: return plan_bp[j] + $signed($urandom_range(2000000)) - 1000000;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // sorted breakpoint for an entry, with a little jitter
  function automatic logic [31:0] sorted_bp(int idx);
    return 32'h8000_0000 + idx * 32'h0400_0000 + $urandom_range(50000);
  endfunction

  // wait until every request is sent and answered
  task automatic wait_drained();
    while (!(pending_requests.size() == 0 && !start && expected_answers.size() == 0))
      @(posedge clk);
  endtask

  // wait for the block to drain, then write the size register
  task automatic set_table_size(logic [plti_pkg::SIZE_W-1:0] sz);
    wait_drained();
    repeat (60) @(posedge clk);
    cfg_valid <= 1'b1;
    table_size <= sz;
    do @(posedge clk); while (!cfg_ready);
    shadow_size = sz;
    cfg_valid <= 1'b0;
    plan_size = (sz == 0) ? 1 : (sz > DEPTH) ? DEPTH : sz;
  endtask

  initial begin
    logic [plti_pkg::SIZE_W-1:0] sizes [7];
    int idx;
    sizes = '{7'd64, 7'd0, 7'd127, 7'd2, 7'd33, 7'd1, 7'd64};
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill every entry with an ascending table so no lookup reads an unwritten entry
    send_idle_pct = 17;
    for (int i = 0; i < DEPTH; i++)
      queue_write(i, sorted_bp(i), $urandom);
    // directed lookups on the size-one table: below, at and above the single breakpoint
    queue_lookup(32'h8000_0000);
    queue_lookup(plan_bp[0]);
    queue_lookup(plan_bp[0] + 1);
    queue_lookup(32'h7fff_ffff);

    for (int p = 0; p < 7; p++) begin
      set_table_size(sizes[p]);
      send_idle_pct = (p < 3) ? 17 : (p < 5) ? 72 : 0;
      if (p == 0) begin
        // directed lookups: both ends, exact breakpoints, interval midpoints; two rewrites store extreme values
        queue_lookup(32'h8000_0000);
        queue_lookup(32'h7fff_ffff);
        queue_lookup(plan_bp[0]);
        queue_lookup(plan_bp[63]);
        queue_lookup(plan_bp[63] + 1);
        queue_lookup(plan_bp[10] + 1);
        queue_lookup(plan_bp[31] + 32'h0200_0000);
        queue_write(5, sorted_bp(5), 32'h7fff_ffff);
        queue_write(6, sorted_bp(6), 32'h8000_0000);
        queue_lookup(plan_bp[5] + 32'h0200_0000);
        queue_lookup(plan_bp[6] - 1);
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 25) begin
          idx = $urandom_range(DEPTH - 1);
          // mostly order-keeping rewrites, some arbitrary ones that unsort the table
          if ($urandom_range(9) < 8) queue_write(idx, sorted_bp(idx), $urandom);
          else queue_write(idx, $urandom, $urandom);
        end else begin
          queue_lookup(aimed_query());
        end
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
